/* hdl/postfix_stack_evaluator_macros.svh */
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another in the next cycle.
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pse_pkg.sv */
`timescale 1ns / 1ps

package pse_pkg;

  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DEPTH_OUT_W = 5;
  localparam int unsigned STATUS_W    = 3;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

/* hdl/pse_if.sv */
`timescale 1ns / 1ps

interface pse_tok_if;
  import pse_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  operand_value;
  logic                       last_token;

  modport source (output valid, action, operand_value, last_token, input ready);
  modport sink   (input valid, action, operand_value, last_token, output ready);
endinterface

interface pse_res_if;
  import pse_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  top_value;
  logic [DEPTH_OUT_W-1:0]     stack_depth;
  logic [STATUS_W-1:0]        status;
  logic                       expression_done;

  modport source (output valid, top_value, stack_depth, status, expression_done, input ready);
  modport sink   (input valid, top_value, stack_depth, status, expression_done, output ready);
endinterface

/* hdl/postfix_stack_evaluator.sv */
// Postfix expression evaluator with a bounded operand stack.
// Tokens arrive on tok_i: push an operand, or add, subtract, multiply or divide
// the two top entries. Each accepted token produces exactly one word on res_o
// with the top of stack, the depth and a status; last_token closes the
// expression, reports its value and empties the stack.
// One token is handled at a time and tok_i is ready only while the sequencer is
// idle. Multiply and divide run on one shared adder that retires one operand
// bit per cycle. The sequencer returns to idle, ready for the next token, on
// the clock edge that registers the result.
// The top entry lives in a register and the rest in a single-port-write RAM
// with a registered read, so an operator needs one RAM read.
// Reset empties the stack and drops any pending output word; RAM contents are
// not cleared and are never read before being written.
// If res_o stalls, the finished word waits in the output register; the
// sequencer holds the following result until that word is taken.
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_macros.svh"

module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pse_tok_if.sink   tok_i,
  pse_res_if.source res_o
);
  import pse_pkg::*;

  localparam int unsigned PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_q;
  logic [PTR_W-1:0]      sp_q;
  logic [STATUS_W-1:0]   st_q;
  logic [WORD_WIDTH-1:0] top_q;
  logic [ACTION_W-1:0]   act_q;
  logic [WORD_WIDTH-1:0] opv_q;
  logic                  last_q;

  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_top_q;
  logic [DEPTH_OUT_W-1:0] out_depth_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_done_q;

  logic                  accept;
  logic                  is_op;
  logic                  full;
  logic                  few;
  logic                  divz;
  logic                  out_load;
  logic [PTR_W-1:0]      sp_m1;
  logic [PTR_W-1:0]      sp_m2;
  logic                  ram_we;
  logic [WORD_WIDTH-1:0] ram_rdata;
  alu_req_t              alu_req;
  logic                  alu_done;
  logic [WORD_WIDTH-1:0] alu_result;
  logic signed [63:0]    opv_ext;
  logic signed [63:0]    top_ext;
  logic [STATUS_W-1:0]   final_status;

  assign accept   = tok_i.valid && tok_i.ready;
  assign full     = (sp_q == PTR_W'(STACK_DEPTH));
  assign few      = (sp_q < PTR_W'(2));
  assign divz     = (act_q == ACT_DIV) && (top_q == '0);
  assign is_op    = (act_q == ACT_ADD) || (act_q == ACT_SUB) ||
                    (act_q == ACT_MUL) || (act_q == ACT_DIV);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || res_o.ready);
  assign sp_m1    = sp_q - PTR_W'(1);
  assign sp_m2    = sp_q - PTR_W'(2);

  assign opv_ext  = 64'(tok_i.operand_value);
  assign top_ext  = 64'(signed'(top_q));

  // On the closing token a clean stack must hold exactly one entry.
  assign final_status = (last_q && (st_q == ST_OK) && (sp_q != PTR_W'(1))) ?
                        ST_MALFORMED : st_q;

  // Push moves the old top into the RAM below the new one.
  assign ram_we = (state_q == S_READ) && (act_q == ACT_PUSH) && !full &&
                  (sp_q != '0);

  pse_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sp_m1[IDX_W-1:0]),
    .wdata_i (top_q),
    .raddr_i (sp_m2[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    alu_req.start = (state_q == S_READ) && is_op && !few && !divz;
    case (act_q)
      ACT_ADD: alu_req.op = ALU_ADD;
      ACT_SUB: alu_req.op = ALU_SUB;
      ACT_MUL: alu_req.op = ALU_MUL;
      default: alu_req.op = ALU_DIV;
    endcase
  end

  pse_alu #(
    .WIDTH (WORD_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (ram_rdata),
    .b_i      (top_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            st_q    <= ST_OK;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_DONE;
          if (act_q == ACT_PUSH) begin
            if (full) begin
              st_q <= ST_OVER;
            end else begin
              sp_q <= sp_q + PTR_W'(1);
            end
          end else if (is_op) begin
            if (few) begin
              st_q <= ST_UNDER;
            end else if (divz) begin
              st_q <= ST_DIVZ;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (alu_done) begin
            sp_q    <= sp_m1;
            state_q <= S_DONE;
          end
        end
        default: begin
          if (out_load) begin
            if (last_q) begin
              sp_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= tok_i.action;
      opv_q  <= opv_ext[WORD_WIDTH-1:0];
      last_q <= tok_i.last_token;
    end
    if ((state_q == S_READ) && (act_q == ACT_PUSH) && !full) begin
      top_q <= opv_q;
    end
    if ((state_q == S_EXEC) && alu_done) begin
      top_q <= alu_result;
    end
    if (out_load) begin
      out_top_q    <= (sp_q != '0) ? top_ext[VALUE_W-1:0] : '0;
      out_depth_q  <= last_q ? '0 : DEPTH_OUT_W'(sp_q);
      out_status_q <= final_status;
      out_done_q   <= last_q;
    end
  end

  assign tok_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = out_valid_q;
  assign res_o.top_value       = out_top_q;
  assign res_o.stack_depth     = out_depth_q;
  assign res_o.status          = out_status_q;
  assign res_o.expression_done = out_done_q;

  `PSE_ASSERT(a_sp_bound, sp_q <= PTR_W'(STACK_DEPTH), "stack pointer beyond depth")
  `PSE_ASSERT_NEXT(a_accept_read, accept, state_q == S_READ, "accept did not start a read")
  `PSE_ASSERT_IMP(a_alu_operands, alu_req.start, sp_q >= PTR_W'(2), "ALU started on short stack")
  `PSE_ASSERT_NEXT(a_alu_finish, (state_q == S_EXEC) && alu_done, state_q == S_DONE, "ALU word lost")
  `PSE_ASSERT_IMP(a_done_empty, out_valid_q && out_done_q, out_depth_q == '0, "bad closing depth")

endmodule

/* hdl/pse_stack_ram.sv */
`timescale 1ns / 1ps

module pse_stack_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pse_alu.sv */
`timescale 1ns / 1ps

module pse_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::alu_req_t req_i,
  input  logic [WIDTH-1:0]  a_i,
  input  logic [WIDTH-1:0]  b_i,
  output logic              done_o,
  output logic [WIDTH-1:0]  result_o
);
  import pse_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_ONE  = 3'd1;
  localparam logic [2:0] P_NEGA = 3'd2;
  localparam logic [2:0] P_NEGB = 3'd3;
  localparam logic [2:0] P_ITER = 3'd4;
  localparam logic [2:0] P_NEGQ = 3'd5;
  localparam logic [2:0] P_FIN  = 3'd6;

  logic [2:0]       phase_q;
  logic [CNT_W-1:0] cnt_q;
  alu_op_e          op_q;
  logic [WIDTH-1:0] x_q;
  logic [WIDTH-1:0] y_q;
  logic [WIDTH:0]   acc_q;
  logic             neg_q;
  logic [WIDTH-1:0] res_q;

  logic [WIDTH:0]   opa;
  logic [WIDTH:0]   opb;
  logic             sub;
  logic [WIDTH:0]   sum;

  // The single shared adder. Multiply runs shift-and-add MSB first; divide runs
  // restoring division, one quotient bit per cycle, on magnitudes.
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (phase_q)
      P_ONE: begin
        opa = {1'b0, x_q};
        opb = {1'b0, y_q};
        sub = (op_q == ALU_SUB);
      end
      P_NEGA, P_NEGQ: begin
        opb = {1'b0, x_q};
        sub = 1'b1;
      end
      P_NEGB: begin
        opb = {1'b0, y_q};
        sub = 1'b1;
      end
      P_ITER: begin
        if (op_q == ALU_MUL) begin
          opa = {1'b0, acc_q[WIDTH-2:0], 1'b0};
          opb = y_q[WIDTH-1] ? {1'b0, x_q} : '0;
        end else begin
          opa = {acc_q[WIDTH-1:0], x_q[WIDTH-1]};
          opb = {1'b0, y_q};
          sub = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign sum = opa + (sub ? ~opb : opb) + {{WIDTH{1'b0}}, sub};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
    end else begin
      case (phase_q)
        P_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              ALU_ADD, ALU_SUB: phase_q <= P_ONE;
              ALU_MUL: begin
                phase_q <= P_ITER;
                cnt_q   <= CNT_W'(WIDTH);
              end
              default: phase_q <= P_NEGA;
            endcase
          end
        end
        P_ONE:  phase_q <= P_FIN;
        P_NEGA: phase_q <= P_NEGB;
        P_NEGB: begin
          phase_q <= P_ITER;
          cnt_q   <= CNT_W'(WIDTH);
        end
        P_ITER: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            phase_q <= (op_q == ALU_MUL) ? P_FIN : P_NEGQ;
          end
        end
        P_NEGQ:  phase_q <= P_FIN;
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          x_q   <= a_i;
          y_q   <= b_i;
          acc_q <= '0;
          op_q  <= req_i.op;
          neg_q <= a_i[WIDTH-1] ^ b_i[WIDTH-1];
        end
      end
      P_ONE: res_q <= sum[WIDTH-1:0];
      P_NEGA: begin
        if (x_q[WIDTH-1]) begin
          x_q <= sum[WIDTH-1:0];
        end
      end
      P_NEGB: begin
        if (y_q[WIDTH-1]) begin
          y_q <= sum[WIDTH-1:0];
        end
      end
      P_ITER: begin
        if (op_q == ALU_MUL) begin
          acc_q <= {1'b0, sum[WIDTH-1:0]};
          y_q   <= {y_q[WIDTH-2:0], 1'b0};
          res_q <= sum[WIDTH-1:0];
        end else begin
          // A clear sign bit means the trial subtraction did not go negative.
          if (!sum[WIDTH]) begin
            acc_q <= sum;
          end else begin
            acc_q <= {acc_q[WIDTH-1:0], x_q[WIDTH-1]};
          end
          x_q <= {x_q[WIDTH-2:0], ~sum[WIDTH]};
        end
      end
      P_NEGQ: res_q <= neg_q ? sum[WIDTH-1:0] : x_q;
      default: begin
      end
    endcase
  end

  assign done_o   = (phase_q == P_FIN);
  assign result_o = res_q;

endmodule

/* test/tb_postfix_stack_evaluator.sv */
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator;
  import pse_pkg::*;

  localparam int unsigned STACK_ENTRIES = 16;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 64;

  // Action codes that the block treats as no operation.
  localparam logic [ACTION_W-1:0] ACT_NOP_5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_NOP_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_NOP_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] WORD_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] WORD_MAX = ~WORD_MIN;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] operand_value;
    logic                      last_token;
  } token_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic [DEPTH_OUT_W-1:0]    stack_depth;
    logic [STATUS_W-1:0]       status;
    logic                      expression_done;
  } result_t;

  logic clk_i;
  logic rst_ni;

  pse_tok_if tok_bus ();
  pse_res_if res_bus ();

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_ENTRIES),
    .WORD_WIDTH (VALUE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok_bus),
    .res_o (res_bus)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Operand stack as the block should hold it.
  logic signed [VALUE_W-1:0] rpn_stack [STACK_ENTRIES];
  int unsigned               rpn_depth;

  result_t     expected_results [$];
  int unsigned failures;
  int unsigned tokens_sent;
  int unsigned results_checked;
  int unsigned expressions_closed;
  int unsigned status_seen [8];

  bit          idle_en;
  bit          hold_go;
  int unsigned hold_len;

  function automatic result_t evaluate_token(input token_t t);
    result_t                   r;
    logic signed [VALUE_W-1:0] lhs, rhs, val;
    logic signed [63:0]        wide_l, wide_r;
    logic [63:0]               mag_l, mag_r, quo;
    logic                      applied;
    r.status = ST_OK;
    applied  = 1'b0;
    val      = '0;
    if (t.action == ACT_PUSH) begin
      if (rpn_depth >= STACK_ENTRIES) begin
        r.status = ST_OVER;
      end else begin
        rpn_stack[rpn_depth] = t.operand_value;
        rpn_depth++;
      end
    end else if (t.action <= ACT_DIV) begin
      if (rpn_depth < 2) begin
        r.status = ST_UNDER;
      end else begin
        rhs     = rpn_stack[rpn_depth-1];
        lhs     = rpn_stack[rpn_depth-2];
        applied = 1'b1;
        case (t.action)
          ACT_ADD: val = lhs + rhs;
          ACT_SUB: val = lhs - rhs;
          ACT_MUL: val = lhs * rhs;
          default: begin
            if (rhs == 0) begin
              r.status = ST_DIVZ;
              applied  = 1'b0;
            end else begin
              // Divide magnitudes so that the most negative word over minus one wraps.
              wide_l = lhs;
              wide_r = rhs;
              mag_l  = (wide_l < 0) ? -wide_l : wide_l;
              mag_r  = (wide_r < 0) ? -wide_r : wide_r;
              quo    = mag_l / mag_r;
              if ((wide_l < 0) != (wide_r < 0)) quo = -quo;
              val = quo[VALUE_W-1:0];
            end
          end
        endcase
        if (applied) begin
          rpn_depth--;
          rpn_stack[rpn_depth-1] = val;
        end
      end
    end
    r.top_value       = (rpn_depth > 0) ? rpn_stack[rpn_depth-1] : '0;
    r.expression_done = t.last_token;
    if (t.last_token) begin
      if (r.status == ST_OK && rpn_depth != 1) r.status = ST_MALFORMED;
      rpn_depth = 0;
    end
    r.stack_depth = DEPTH_OUT_W'(rpn_depth);
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
    else if (pick < 16) return $urandom;
    else if (pick == 16) return WORD_MIN;
    else if (pick == 17) return WORD_MAX;
    else if (pick == 18) return '0;
    else return $urandom_range(0, 1) ? -1 : 1;
  endfunction

  function automatic logic [ACTION_W-1:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return ACT_ADD;
      1:       return ACT_SUB;
      2:       return ACT_MUL;
      default: return ACT_DIV;
    endcase
  endfunction

  // Offers one word on the token channel and books its expected result once taken.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_token(input logic [ACTION_W-1:0] act,
                            input logic signed [VALUE_W-1:0] value,
                            input logic last);
    token_t      tk;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 8);
      tok_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tk.action             = act;
    tk.operand_value      = value;
    tk.last_token         = last;
    tok_bus.action        = act;
    tok_bus.operand_value = value;
    tok_bus.last_token    = last;
    tok_bus.valid         = 1'b1;
    do @(posedge clk_i); while (!tok_bus.ready);
    expected_results.push_back(evaluate_token(tk));
    tokens_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    tok_bus.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_arith_ops();
    send_token(ACT_PUSH, 7, 1'b0);
    send_token(ACT_PUSH, 3, 1'b0);
    send_token(ACT_ADD, 0, 1'b0);
    send_token(ACT_PUSH, 4, 1'b0);
    send_token(ACT_SUB, 0, 1'b0);
    send_token(ACT_PUSH, -3, 1'b0);
    send_token(ACT_MUL, 0, 1'b0);
    send_token(ACT_PUSH, 4, 1'b0);
    send_token(ACT_DIV, 0, 1'b1);
    // Addition past the largest word wraps around.
    send_token(ACT_PUSH, WORD_MAX, 1'b0);
    send_token(ACT_PUSH, 1, 1'b0);
    send_token(ACT_ADD, 0, 1'b1);
  endtask

  task automatic test_error_cases();
    send_token(ACT_ADD, 0, 1'b0);
    send_token(ACT_PUSH, 5, 1'b0);
    send_token(ACT_PUSH, 0, 1'b0);
    send_token(ACT_DIV, 0, 1'b0);
    send_token(ACT_SUB, 0, 1'b1);
    send_token(ACT_PUSH, WORD_MIN, 1'b0);
    send_token(ACT_PUSH, -1, 1'b0);
    send_token(ACT_DIV, 0, 1'b1);
    send_token(ACT_PUSH, WORD_MAX, 1'b0);
    send_token(ACT_NOP_5, -1, 1'b0);
    send_token(ACT_NOP_6, WORD_MIN, 1'b0);
    send_token(ACT_NOP_7, 0, 1'b1);
    // An error on the last token keeps its own status rather than malformed.
    send_token(ACT_PUSH, 1, 1'b0);
    send_token(ACT_MUL, 0, 1'b1);
    send_token(ACT_PUSH, 1, 1'b0);
    send_token(ACT_PUSH, 2, 1'b1);
  endtask

  task automatic run_random_expressions(input int unsigned n_tokens);
    token_t      expr [$];
    token_t      tk;
    int unsigned sent, kind, n_opnd, pushed, depth;
    sent = 0;
    while (sent < n_tokens) begin
      expr.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 4)) begin
          tk.action        = ACTION_W'($urandom_range(0, 7));
          tk.operand_value = random_operand();
          tk.last_token    = ($urandom_range(0, 4) == 0);
          expr.push_back(tk);
        end
      end else if (kind < 11) begin
        // Push a long run, up to and often past a full stack.
        repeat ($urandom_range(STACK_ENTRIES - 1, STACK_ENTRIES + 4)) begin
          tk.action        = ACT_PUSH;
          tk.operand_value = random_operand();
          tk.last_token    = 1'b0;
          expr.push_back(tk);
        end
        expr[expr.size()-1].last_token = 1'b1;
      end else begin
        n_opnd = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 6);
        pushed = 0;
        depth  = 0;
        while (!(pushed == n_opnd && depth == 1)) begin
          tk.last_token = 1'b0;
          if (pushed < n_opnd && (depth < 2 || $urandom_range(0, 1))) begin
            tk.action        = ACT_PUSH;
            tk.operand_value = random_operand();
            pushed++;
            depth++;
          end else begin
            tk.action        = random_operator();
            tk.operand_value = $urandom;
            depth--;
          end
          expr.push_back(tk);
        end
        // Now and then an expression is left open so the next one builds on it.
        expr[expr.size()-1].last_token = (kind >= 14);
      end
      foreach (expr[i]) begin
        send_token(expr[i].action, expr[i].operand_value, expr[i].last_token);
      end
      sent += expr.size();
    end
  endtask

  // The result side stalls for a long stretch while tokens keep coming, so the
  // block backs up and holds its input; the sender then waits for the drain.
  task automatic test_backpressure();
    hold_len = 200;
    hold_go  = 1'b1;
    for (int i = 0; i < STACK_ENTRIES + 2; i++) begin
      send_token(ACT_PUSH, random_operand(), i == STACK_ENTRIES + 1);
    end
    wait_results_done();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_left = hold_len;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = !(idle_en && $urandom_range(0, 99) < 12);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no token pending: top_value %0d", res_bus.top_value);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (res_bus.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, res_bus.top_value);
          failures++;
        end
        if (res_bus.stack_depth !== want.stack_depth) begin
          $error("stack_depth: expected %0d, got %0d", want.stack_depth, res_bus.stack_depth);
          failures++;
        end
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_bus.status);
          failures++;
        end
        if (res_bus.expression_done !== want.expression_done) begin
          $error("expression_done: expected %0b, got %0b", want.expression_done,
                 res_bus.expression_done);
          failures++;
        end
        results_checked++;
        status_seen[want.status]++;
        if (want.expression_done) expressions_closed++;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $error("run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT,
           expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    tok_bus.valid         = 1'b0;
    tok_bus.action        = ACT_PUSH;
    tok_bus.operand_value = '0;
    tok_bus.last_token    = 1'b0;
    res_bus.ready         = 1'b0;
    rst_ni                = 1'b0;
    idle_en               = 1'b1;
    hold_go               = 1'b0;
    hold_len              = 0;
    rpn_depth             = 0;
    failures              = 0;
    tokens_sent           = 0;
    results_checked       = 0;
    expressions_closed    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_arith_ops();
    test_error_cases();
    wait_results_done();
    run_random_expressions(200);
    wait_results_done();
    idle_en = 1'b0;
    run_random_expressions(150);
    idle_en = 1'b1;
    test_backpressure();
    run_random_expressions(80);
    wait_results_done();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end

    $display("Covered %0d tokens and %0d checked results over %0d closed expressions.",
             tokens_sent, results_checked, expressions_closed);
    $display("Status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, malformed %0d.",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIVZ], status_seen[ST_MALFORMED]);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
